>>> design/gsfp_pkg.sv
// Package for the gas sensor frame parser: codes, result types and frame constants.
// No dependencies; every other design file imports it.
package gsfp_pkg;

    localparam int unsigned FRAME_LEN     = 11;
    localparam int unsigned CHECK_POS     = 10;
    localparam int unsigned PAYLOAD_DEPTH = 8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
    localparam int unsigned PADDR_W       = 3;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_TIMEOUT  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0
    } reg_idx_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] co_ppm;
        logic [15:0] h2s_ppm;
        logic [15:0] o2_tenths;
        logic [15:0] ch4_value;
    } result_t;

    typedef struct packed {
        logic       window_open;
        logic [3:0] byte_index;
        logic       result_valid;
    } core_status_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } stage_status_t;

endpackage

>>> design/gsfp_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on gsfp_pkg for the result status type.
interface gsfp_in_if;
    import gsfp_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface gsfp_out_if;
    import gsfp_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] co_ppm;
    logic [15:0] h2s_ppm;
    logic [15:0] o2_tenths;
    logic [15:0] ch4_value;

    modport source (output valid, output status, output co_ppm, output h2s_ppm,
                    output o2_tenths, output ch4_value, input ready);
    modport sink (input valid, input status, input co_ppm, input h2s_ppm,
                  input o2_tenths, input ch4_value, output ready);
endinterface

>>> design/gsfp_cfg_regs.sv
// APB-style configuration register holding the frame timeout in milliseconds.
// Depends on gsfp_pkg for the register index and reset value.
module gsfp_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gsfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 timeout_ms
);
    import gsfp_pkg::*;

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[PADDR_W-1] == REG_TIMEOUT);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata     = hit ? {16'd0, timeout_reg} : 32'd0;
    assign timeout_ms = timeout_reg;
endmodule

>>> design/gsfp_frame_core.sv
// Frame state, checksum and timeout logic; turns one accepted beat into at most one result.
// Depends on gsfp_pkg for codes and the result type.
module gsfp_frame_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             func,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            timeout_ms,
    output gsfp_pkg::result_t      result,
    output gsfp_pkg::core_status_t core_status
);
    import gsfp_pkg::*;

    logic        window_open_reg, window_open_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  payload_reg [PAYLOAD_DEPTH];
    logic        payload_we;
    logic [2:0]  payload_idx;
    logic        result_valid;
    logic [7:0]  expect_sum;
    logic [3:0]  idx_minus2;

    assign expect_sum = 8'd0 - running_sum_reg;
    assign idx_minus2 = byte_index_reg - 4'd2;
    assign payload_idx = idx_minus2[2:0];

    always_comb
    begin
        window_open_next = window_open_reg;
        byte_index_next  = byte_index_reg;
        running_sum_next = running_sum_reg;
        elapsed_next     = elapsed_reg;
        payload_we       = 1'b0;
        result_valid     = 1'b0;
        result.status    = STATUS_OK;
        result.co_ppm    = {payload_reg[0], payload_reg[1]};
        result.h2s_ppm   = {payload_reg[2], payload_reg[3]};
        result.o2_tenths = {payload_reg[4], payload_reg[5]};
        result.ch4_value = {payload_reg[6], payload_reg[7]};
        if (accept)
        begin
            case (func_t'(func))
                FUNC_START:
                begin
                    window_open_next = 1'b1;
                    byte_index_next  = 4'd0;
                    running_sum_next = 8'd0;
                    elapsed_next     = 16'd0;
                end
                FUNC_BYTE:
                begin
                    if (window_open_reg)
                    begin
                        if (byte_index_reg >= 4'(CHECK_POS))
                        begin
                            window_open_next = 1'b0;
                            byte_index_next  = 4'd0;
                            result_valid     = 1'b1;
                            if (expect_sum != rx_byte)
                            begin
                                result.status    = STATUS_CHECKSUM;
                                result.co_ppm    = 16'd0;
                                result.h2s_ppm   = 16'd0;
                                result.o2_tenths = 16'd0;
                                result.ch4_value = 16'd0;
                            end
                        end
                        else
                        begin
                            if (byte_index_reg >= 4'd1)
                            begin
                                running_sum_next = running_sum_reg + rx_byte;
                            end
                            payload_we      = (byte_index_reg >= 4'd2);
                            byte_index_next = byte_index_reg + 4'd1;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (window_open_reg)
                    begin
                        if (elapsed_reg != ELAPSED_MAX)
                        begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                        if (elapsed_next >= timeout_ms)
                        begin
                            window_open_next = 1'b0;
                            byte_index_next  = 4'd0;
                            result_valid     = 1'b1;
                            result.status    = STATUS_TIMEOUT;
                            result.co_ppm    = 16'd0;
                            result.h2s_ppm   = 16'd0;
                            result.o2_tenths = 16'd0;
                            result.ch4_value = 16'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_open_reg <= 1'b0;
            byte_index_reg  <= 4'd0;
            running_sum_reg <= 8'd0;
            elapsed_reg     <= 16'd0;
        end
        else
        begin
            window_open_reg <= window_open_next;
            byte_index_reg  <= byte_index_next;
            running_sum_reg <= running_sum_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload_we)
        begin
            payload_reg[payload_idx] <= rx_byte;
        end
    end

    assign core_status.window_open  = window_open_reg;
    assign core_status.byte_index   = byte_index_reg;
    assign core_status.result_valid = result_valid;
endmodule

>>> design/gsfp_out_stage.sv
// Two-entry result register with skid slot; parts the input side from output stalls.
// Depends on gsfp_pkg for the result type.
module gsfp_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gsfp_pkg::result_t       push_data,
    output logic                    accept_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output gsfp_pkg::result_t       out_data,
    output gsfp_pkg::stage_status_t stage_status
);
    import gsfp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign accept_ready            = !skid_valid_reg;
    assign out_valid               = main_valid_reg;
    assign out_data                = main_reg;
    assign stage_status.main_valid = main_valid_reg;
    assign stage_status.skid_valid = skid_valid_reg;
endmodule

>>> design/gas_sensor_frame_parser_unit.sv
// Top level of the gas sensor frame parser: channels, config port, core and result stage.
// Depends on gsfp_pkg, gsfp_if, gsfp_cfg_regs, gsfp_frame_core and gsfp_out_stage.
//
// Usage:
//   The input channel carries one beat per start, received byte or millisecond tick.
//   A start opens a receive window; bytes 0..10 of the frame follow. Byte 10 yields
//   one result beat: status ok with CO, H2S, O2 and CH4 readings, or checksum
//   mismatch with zero readings. A tick that brings the elapsed count to
//   timeout_ms yields a timeout result. Bytes and ticks outside a window drop.
//   A result is registered in the result register, or the skid slot while the receiver
//   stalls. Throughput: one input beat per cycle while input ready is high, set by the
//   single pass of frame logic between the input handshake and the result register.
//   Receiver stall: results queue in a result register plus one skid slot; input
//   ready falls only while both hold a result.
//   Reset: window closed, counters cleared, timeout_ms back to 200, output empty.
//   The timeout register answers at byte addresses 0 to 3 of the APB-style port; write it
//   only while the block is idle.
module gas_sensor_frame_parser_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    gsfp_in_if.sink                      in,
    gsfp_out_if.source                   out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import gsfp_pkg::*;

    logic          [15:0] timeout_ms;
    logic                 accept;
    logic                 accept_ready;
    result_t              core_result;
    result_t              out_data;
    core_status_t         core_status;
    stage_status_t        stage_status;

    gsfp_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeout_ms (timeout_ms)
    );

    assign in.ready = accept_ready;
    assign accept   = in.valid && accept_ready;

    gsfp_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (in.func),
        .rx_byte     (in.rx_byte),
        .timeout_ms  (timeout_ms),
        .result      (core_result),
        .core_status (core_status)
    );

    gsfp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (core_status.result_valid),
        .push_data    (core_result),
        .accept_ready (accept_ready),
        .out_valid    (out.valid),
        .out_ready    (out.ready),
        .out_data     (out_data),
        .stage_status (stage_status)
    );

    assign out.status    = out_data.status;
    assign out.co_ppm    = out_data.co_ppm;
    assign out.h2s_ppm   = out_data.h2s_ppm;
    assign out.o2_tenths = out_data.o2_tenths;
    assign out.ch4_value = out_data.ch4_value;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        stage_status.skid_valid |-> stage_status.main_valid)
        else $error("skid slot holds a result while result register is empty");

    a_closed_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !core_status.window_open |-> (core_status.byte_index == 4'd0))
        else $error("byte index nonzero with window closed");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.byte_index <= 4'(CHECK_POS))
        else $error("byte index past checksum position");

    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.result_valid |=> !core_status.window_open)
        else $error("window still open after a result");
endmodule
